/* rtl/core/hcc_pkg.sv */
// hcc_pkg: shared types and constants of the crater carver.
// No dependencies; imported by the interfaces and every module of the block.
package hcc_pkg;

    localparam int POS_W      = 13;   // signed world coordinate
    localparam int ROW_W      = 12;   // surface row / floor row
    localparam int RAD_W      = 8;    // crater radius
    localparam int SUM_W      = 14;   // signed sums of a coordinate and a small offset
    localparam int SQ_W       = 16;   // radius squared and its remainders
    localparam int ROOT_W     = 8;    // floored root of a SQ_W value
    localparam int SQRT_STEPS = 8;    // one result bit per step
    localparam int STEP_W     = 3;

    localparam logic [ROW_W-1:0] FLOOR_RESET = 12'd720;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_CARVE = 2'd1,
        ACT_PROBE = 2'd2,
        ACT_NONE  = 2'd3
    } hcc_action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_COL,
        ST_SQRT,
        ST_WAIT,
        ST_WR,
        ST_PROBE,
        ST_DONE
    } hcc_state_t;

    // handshake between the sequencer and the root unit
    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] operand;
    } hcc_sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } hcc_sqrt_rsp_t;

endpackage

/* rtl/core/hcc_if.sv */
// Channel interfaces of the crater carver: command, result and config write.
// Depends on hcc_pkg for field widths.
interface hcc_cmd_if import hcc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [RAD_W-1:0]        radius;
    logic [ROW_W-1:0]        column_height;

    modport source (output valid, action, pos_x, pos_y, radius, column_height,
                    input ready);
    modport sink   (input valid, action, pos_x, pos_y, radius, column_height,
                    output ready);
endinterface

interface hcc_res_if import hcc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] surface_row;
    logic             inside_res;
    logic             fully_gone;

    modport source (output valid, surface_row, inside_res, fully_gone, input ready);
    modport sink   (input valid, surface_row, inside_res, fully_gone, output ready);
endinterface

interface hcc_cfg_if import hcc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] floor_row;

    modport source (output valid, floor_row, input ready);
    modport sink   (input valid, floor_row, output ready);
endinterface

/* rtl/core/heightmap_crater_carver_core.sv */
// heightmap_crater_carver_core: top level of the crater carver.
// Depends on hcc_pkg, hcc_if, hcc_isqrt and hcc_col_mem.
//
// Usage
//   cmd  : one item per command (write column, carve crater, probe point).
//          ready is high only while the sequencer is idle; an item is taken
//          on a clock edge with valid and ready both high.
//   res  : exactly one item per command. Probe items carry the column's row,
//          the at-or-below flag and the dug-out flag; other commands give
//          an all-zero item.
//   cfg  : floor_row write; always ready, meant to be written while idle.
// Order: the result register is loaded after the dispatch and done states
//   for write and unused codes, after dispatch, probe and done for probe. A
//   carve visits every column between the clamped ends of the range, at most
//   511: one outside the radius uses only the column state, one inside it adds
//   table read, 8-step root unit, clamp and write back; the root unit dominates.
// Back-pressure: the result sits in an output register; the next command is
//   taken while it waits. The sequencer holds in its final state only when a
//   second result is ready and the first has not yet been taken.
// Reset: control state clears, floor_row returns to 720. The column table
//   is not cleared; columns must be written before they are read or carved.
module heightmap_crater_carver_core import hcc_pkg::*;
#(
    parameter int COLUMNS = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    hcc_cfg_if.sink    cfg,
    hcc_cmd_if.sink    cmd,
    hcc_res_if.source  res
);

    localparam int CW = $clog2(COLUMNS);
    localparam logic signed [SUM_W-1:0] LAST_COL = SUM_W'(COLUMNS - 1);

    // clamp a signed column number to the table
    function automatic logic [CW-1:0] clamp_col(input logic signed [SUM_W-1:0] c);
        logic [CW-1:0] r;
        if (c < 0)
            r = '0;
        else if (c > LAST_COL)
            r = CW'(COLUMNS - 1);
        else
            r = c[CW-1:0];
        return r;
    endfunction

    hcc_state_t state_reg, state_next;

    // latched command
    hcc_action_t             act_reg;
    logic signed [POS_W-1:0] px_reg;
    logic signed [POS_W-1:0] py_reg;
    logic [RAD_W-1:0]        r_reg;
    logic [ROW_W-1:0]        ch_reg;
    logic [SQ_W-1:0]         rsq_reg;

    // carve walk
    logic [CW-1:0]           x_reg;
    logic [CW-1:0]           last_reg;
    logic [SQ_W-1:0]         rem_reg;
    logic signed [SUM_W-1:0] fl_reg;

    // pending result and output register
    logic [ROW_W-1:0] rsl_row_reg;
    logic             rsl_in_reg;
    logic             rsl_gone_reg;
    logic             out_valid_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic             out_in_reg;
    logic             out_gone_reg;

    logic [ROW_W-1:0] floor_row_reg;

    logic accept;
    logic out_free;

    // datapath nets
    logic signed [SUM_W-1:0] px_ext;
    logic signed [SUM_W-1:0] py_ext;
    logic signed [SUM_W-1:0] floor_ext;
    logic [CW-1:0]           px_col;
    logic signed [SUM_W-1:0] dx;
    logic [SUM_W-1:0]        absdx;
    logic                    in_rad;
    logic [SQ_W-1:0]         dxsq;
    logic signed [SUM_W-1:0] fl_sum;
    logic signed [ROW_W:0]   gone_thr;
    logic                    last_col;

    // memory and root unit controls
    logic             mem_wr_en;
    logic [CW-1:0]    mem_wr_addr;
    logic [ROW_W-1:0] mem_wr_data;
    logic             mem_rd_en;
    logic [CW-1:0]    mem_rd_addr;
    logic [ROW_W-1:0] mem_rd_data;
    hcc_sqrt_req_t    sqrt_req;
    hcc_sqrt_rsp_t    sqrt_rsp;

    assign accept   = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || res.ready;

    assign px_ext    = SUM_W'(px_reg);
    assign py_ext    = SUM_W'(py_reg);
    assign floor_ext = $signed({2'b00, floor_row_reg});
    assign px_col    = clamp_col(px_ext);

    assign dx       = $signed(SUM_W'(x_reg)) - px_ext;
    assign absdx    = dx[SUM_W-1] ? SUM_W'(-dx) : SUM_W'(dx);
    assign in_rad   = absdx < SUM_W'(r_reg);
    assign dxsq     = absdx[RAD_W-1:0] * absdx[RAD_W-1:0];
    assign fl_sum   = py_ext + $signed(SUM_W'(sqrt_rsp.root));
    assign gone_thr = $signed({1'b0, floor_row_reg}) - 13'sd1;
    assign last_col = x_reg == last_reg;

    hcc_col_mem #(
        .COLUMNS (COLUMNS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    hcc_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                case (act_reg)
                    ACT_CARVE: state_next = ST_COL;
                    ACT_PROBE: state_next = ST_PROBE;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_COL:
            begin
                if (in_rad)
                    state_next = ST_SQRT;
                else if (last_col)
                    state_next = ST_DONE;
            end
            ST_SQRT:  state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (sqrt_rsp.done)
                    state_next = ST_WR;
            end
            ST_WR:    state_next = last_col ? ST_DONE : ST_COL;
            ST_PROBE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        mem_wr_en        = 1'b0;
        mem_wr_addr      = x_reg;
        mem_wr_data      = fl_reg[ROW_W-1:0];
        mem_rd_en        = 1'b0;
        mem_rd_addr      = x_reg;
        sqrt_req.start   = 1'b0;
        sqrt_req.operand = rem_reg;
        case (state_reg)
            ST_DISPATCH:
            begin
                mem_wr_en   = act_reg == ACT_WRITE;
                mem_wr_addr = px_col;
                mem_wr_data = ch_reg;
                mem_rd_en   = act_reg == ACT_PROBE;
                mem_rd_addr = px_col;
            end
            ST_COL:
            begin
                mem_rd_en = in_rad;
            end
            ST_SQRT:
            begin
                sqrt_req.start = 1'b1;
            end
            ST_WR:
            begin
                // lower the surface only when the crater floor is deeper
                mem_wr_en = fl_reg > $signed({2'b00, mem_rd_data});
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    assign cmd.ready = state_reg == ST_IDLE;
    assign cfg.ready = 1'b1;

    assign res.valid       = out_valid_reg;
    assign res.surface_row = out_row_reg;
    assign res.inside_res  = out_in_reg;
    assign res.fully_gone  = out_gone_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            floor_row_reg <= FLOOR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                floor_row_reg <= cfg.floor_row;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= hcc_action_t'(cmd.action);
            px_reg       <= cmd.pos_x;
            py_reg       <= cmd.pos_y;
            r_reg        <= cmd.radius;
            ch_reg       <= cmd.column_height;
            rsq_reg      <= cmd.radius * cmd.radius;
            rsl_row_reg  <= '0;
            rsl_in_reg   <= 1'b0;
            rsl_gone_reg <= 1'b0;
        end

        case (state_reg)
            ST_DISPATCH:
            begin
                x_reg    <= clamp_col(px_ext - $signed(SUM_W'(r_reg)));
                last_reg <= clamp_col(px_ext + $signed(SUM_W'(r_reg)));
            end
            ST_COL:
            begin
                rem_reg <= rsq_reg - dxsq;
                if (!in_rad && !last_col)
                    x_reg <= x_reg + CW'(1);
            end
            ST_WAIT:
            begin
                if (sqrt_rsp.done)
                    fl_reg <= (fl_sum > floor_ext) ? floor_ext : fl_sum;
            end
            ST_WR:
            begin
                if (!last_col)
                    x_reg <= x_reg + CW'(1);
            end
            ST_PROBE:
            begin
                rsl_row_reg  <= mem_rd_data;
                rsl_in_reg   <= py_ext >= $signed({2'b00, mem_rd_data});
                rsl_gone_reg <= $signed({1'b0, mem_rd_data}) >= gone_thr;
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase

        if (state_reg == ST_DONE && out_free)
        begin
            out_row_reg  <= rsl_row_reg;
            out_in_reg   <= rsl_in_reg;
            out_gone_reg <= rsl_gone_reg;
        end
    end

`ifndef ASSERT_OFF
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DISPATCH)
        else $error("accepted item did not reach dispatch");

    a_root_expected: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_rsp.done |-> state_reg == ST_WAIT)
        else $error("root result arrived outside the wait state");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COL || state_reg == ST_WR) |-> x_reg <= last_reg)
        else $error("carve walk ran past its last column");

    a_floor_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR |-> fl_reg <= floor_ext)
        else $error("crater floor above clamp");
`endif

endmodule

/* rtl/core/hcc_isqrt.sv */
// hcc_isqrt: floored square root, one result bit per cycle.
// Depends on hcc_pkg (widths, request/response structs).
module hcc_isqrt import hcc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  hcc_sqrt_req_t req,
    output hcc_sqrt_rsp_t rsp
);

    logic [SQ_W-1:0]   v_reg;
    logic [SQ_W-1:0]   res_reg;
    logic [SQ_W-1:0]   bit_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [SQ_W:0]     trial;
    logic              take;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign take  = {1'b0, v_reg} >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: no reset needed
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            v_reg   <= req.operand;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                v_reg   <= v_reg - trial[SQ_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[ROOT_W-1:0];

endmodule

/* rtl/core/hcc_col_mem.sv */
// hcc_col_mem: surface row table, one write and one registered read port.
// Depends on hcc_pkg (row width).
module hcc_col_mem import hcc_pkg::*;
#(
    parameter int COLUMNS = 1024
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(COLUMNS)-1:0] wr_addr,
    input  logic [ROW_W-1:0]           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(COLUMNS)-1:0] rd_addr,
    output logic [ROW_W-1:0]           rd_data
);

    logic [ROW_W-1:0] mem [COLUMNS];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
